// ===== design/ppt_pkg.sv =====
// ----------------------------------------------------------------------------
// ppt_pkg: shared definitions for the prime / palindrome test core
// Widths, fixed operands and the divider status struct used by the core
// and its shared divider.
// ----------------------------------------------------------------------------
package ppt_pkg;

   // width of the signed input number
   localparam int VALUE_BITS = 32;
   // magnitude bits of a non-negative input
   localparam int MAG_BITS   = VALUE_BITS - 1;
   // digit reversal of a MAG_BITS number stays below ten times its maximum
   localparam int REV_BITS   = MAG_BITS + 4;
   // divider step counter holds MAG_BITS itself
   localparam int CNT_BITS   = $clog2(MAG_BITS + 1);

   // decimal radix for digit extraction
   localparam logic [MAG_BITS-1:0] DIV_TEN     = MAG_BITS'(10);
   // first trial divisor and smallest prime
   localparam logic [MAG_BITS-1:0] FIRST_TRIAL = MAG_BITS'(2);

   // divider status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== design/ppt_divider.sv =====
// ----------------------------------------------------------------------------
// ppt_divider: restoring radix-2 divider
// Unsigned MAG_BITS / MAG_BITS division, one quotient bit per cycle.
// Quotient and remainder are valid in the cycle that status.done is high.
// ----------------------------------------------------------------------------
module ppt_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [ppt_pkg::MAG_BITS-1:0] dividend,
   input  logic [ppt_pkg::MAG_BITS-1:0] divisor,
   output ppt_pkg::div_status_type      status,
   output logic [ppt_pkg::MAG_BITS-1:0] quotient,
   output logic [ppt_pkg::MAG_BITS-1:0] remainder
);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [ppt_pkg::CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [ppt_pkg::MAG_BITS-1:0] quo_ff, quo_in;
   logic [ppt_pkg::MAG_BITS-1:0] rem_ff, rem_in;
   logic [ppt_pkg::MAG_BITS:0]   shifted;
   logic [ppt_pkg::MAG_BITS:0]   diff;

   // shift in the next dividend bit and try the subtraction
   assign shifted = {rem_ff, quo_ff[ppt_pkg::MAG_BITS-1]};
   assign diff    = shifted - {1'b0, divisor};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (!busy_ff && start) begin
         // load operands
         busy_in = 1'b1;
         cnt_in  = ppt_pkg::CNT_BITS'(ppt_pkg::MAG_BITS);
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         // restore or keep the difference, shift the quotient bit in
         if (shifted >= {1'b0, divisor}) begin
            rem_in = diff[ppt_pkg::MAG_BITS-1:0];
            quo_in = {quo_ff[ppt_pkg::MAG_BITS-2:0], 1'b1};
         end else begin
            rem_in = shifted[ppt_pkg::MAG_BITS-1:0];
            quo_in = {quo_ff[ppt_pkg::MAG_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == ppt_pkg::CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;
   assign remainder   = rem_ff;

endmodule

// ===== design/prime_palindrome_test_core.sv =====
// ----------------------------------------------------------------------------
// prime_palindrome_test_core: trial-division primality and palindrome test
// Classifies one signed number per word as prime, decimal palindrome, both.
// ----------------------------------------------------------------------------
// One word is in work at a time; req_ready is high only while the core is
// idle, and a finished result may still wait on the rsp_ side while the next
// word is taken. Every division runs through one shared radix-2 divider.
// A word costs one division per decimal digit for the reversal plus one per
// trial divisor from 2 until a factor is found or the divisor passes the
// square root; negative values skip both and go straight to the result.
// ----------------------------------------------------------------------------
module prime_palindrome_test_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [ppt_pkg::VALUE_BITS-1:0] req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_is_prime,
   output logic                                  rsp_is_palindrome,
   output logic                                  rsp_is_prime_palindrome
);

   typedef enum logic [5:0] {
      S_IDLE      = 6'b000001,
      S_REV_ISSUE = 6'b000010,
      S_REV_WAIT  = 6'b000100,
      S_PRM_ISSUE = 6'b001000,
      S_PRM_WAIT  = 6'b010000,
      S_DONE      = 6'b100000
   } state_type;

   state_type                    state_ff, state_in;
   logic [ppt_pkg::MAG_BITS-1:0] mag_ff, mag_in;
   logic [ppt_pkg::MAG_BITS-1:0] num_ff, num_in;
   logic [ppt_pkg::REV_BITS-1:0] rev_ff, rev_in;
   logic [ppt_pkg::MAG_BITS-1:0] trial_ff, trial_in;
   logic                         prime_ff, prime_in;
   logic                         pal_ff, pal_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_prime_ff, rsp_prime_in;
   logic                         rsp_pal_ff, rsp_pal_in;
   logic                         rsp_both_ff, rsp_both_in;

   logic                         div_start;
   logic [ppt_pkg::MAG_BITS-1:0] div_dividend;
   logic [ppt_pkg::MAG_BITS-1:0] div_divisor;
   ppt_pkg::div_status_type      div_status;
   logic [ppt_pkg::MAG_BITS-1:0] div_quotient;
   logic [ppt_pkg::MAG_BITS-1:0] div_remainder;

   ppt_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .status    (div_status),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   // sequence reversal digits, then trial divisors
   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      num_in       = num_ff;
      rev_in       = rev_ff;
      trial_in     = trial_ff;
      prime_in     = prime_ff;
      pal_in       = pal_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_prime_in = rsp_prime_ff;
      rsp_pal_in   = rsp_pal_ff;
      rsp_both_in  = rsp_both_ff;
      div_start    = 1'b0;
      div_dividend = mag_ff;
      div_divisor  = trial_ff;

      // drop the result once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               mag_in   = req_value[ppt_pkg::MAG_BITS-1:0];
               num_in   = req_value[ppt_pkg::MAG_BITS-1:0];
               rev_in   = '0;
               prime_in = 1'b0;
               pal_in   = 1'b0;
               // negative words are neither prime nor palindrome
               if (req_value[ppt_pkg::VALUE_BITS-1]) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_REV_ISSUE;
               end
            end
         end
         S_REV_ISSUE: begin
            div_dividend = num_ff;
            div_divisor  = ppt_pkg::DIV_TEN;
            if (num_ff == '0) begin
               // all digits consumed: compare reversal with the value
               pal_in   = (rev_ff == ppt_pkg::REV_BITS'(mag_ff));
               trial_in = ppt_pkg::FIRST_TRIAL;
               state_in = S_PRM_ISSUE;
            end else begin
               div_start = 1'b1;
               state_in  = S_REV_WAIT;
            end
         end
         S_REV_WAIT: begin
            div_dividend = num_ff;
            div_divisor  = ppt_pkg::DIV_TEN;
            if (div_status.done) begin
               // append the low digit to the reversal
               rev_in   = (rev_ff << 3) + (rev_ff << 1)
                        + ppt_pkg::REV_BITS'(div_remainder);
               num_in   = div_quotient;
               state_in = S_REV_ISSUE;
            end
         end
         S_PRM_ISSUE: begin
            if (mag_ff < ppt_pkg::FIRST_TRIAL) begin
               prime_in = 1'b0;
               state_in = S_DONE;
            end else begin
               div_start = 1'b1;
               state_in  = S_PRM_WAIT;
            end
         end
         S_PRM_WAIT: begin
            if (div_status.done) begin
               // divisor past the square root: no factor found
               if (trial_ff > div_quotient) begin
                  prime_in = 1'b1;
                  state_in = S_DONE;
               end else if (div_remainder == '0) begin
                  prime_in = 1'b0;
                  state_in = S_DONE;
               end else begin
                  trial_in = trial_ff + 1'b1;
                  state_in = S_PRM_ISSUE;
               end
            end
         end
         S_DONE: begin
            // hand over once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_prime_in = prime_ff;
               rsp_pal_in   = pal_ff;
               rsp_both_in  = prime_ff && pal_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff       <= mag_in;
      num_ff       <= num_in;
      rev_ff       <= rev_in;
      trial_ff     <= trial_in;
      prime_ff     <= prime_in;
      pal_ff       <= pal_in;
      rsp_prime_ff <= rsp_prime_in;
      rsp_pal_ff   <= rsp_pal_in;
      rsp_both_ff  <= rsp_both_in;
   end

   assign req_ready               = (state_ff == S_IDLE);
   assign rsp_valid               = rsp_valid_ff;
   assign rsp_is_prime            = rsp_prime_ff;
   assign rsp_is_palindrome       = rsp_pal_ff;
   assign rsp_is_prime_palindrome = rsp_both_ff;

   // divider is never restarted while a division is running
   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_status.busy)
      else $error("divider started while busy");

   // negative word goes straight to the result with both flags clear
   a_negative_fast: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_value[ppt_pkg::VALUE_BITS-1])
      |=> (state_ff == S_DONE) && !prime_ff && !pal_ff)
      else $error("negative word not short-cut");

   // trial divisor never drops below two while dividing
   a_trial_floor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PRM_WAIT) |-> (trial_ff >= ppt_pkg::FIRST_TRIAL))
      else $error("trial divisor below two");

   // combined flag agrees with the two single flags
   a_both_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_both_ff == (rsp_prime_ff && rsp_pal_ff)))
      else $error("combined flag mismatch");

endmodule

// ===== tb/sv/tb_prime_palindrome_test_core.sv =====
// ----------------------------------------------------------------------------
// tb_prime_palindrome_test_core: self-checking bench for the prime / palindrome
// test core
// Sends signed words through the req_ channel and checks every rsp_ word
// against an in-bench classifier. The classifier does trial division and
// digit reversal in 64-bit arithmetic. Directed words hit zero, one,
// negatives, both ends of the range, squares of primes and prime
// palindromes. Random words mix small, negative, wide, palindromic and
// near-boundary values. Both sides stall at random, with one back-to-back
// stretch and one pause that drains the core.
// ----------------------------------------------------------------------------
module tb_prime_palindrome_test_core;

   // trial divisors allowed for one random word, keeps the run short
   localparam int unsigned TRIAL_BUDGET   = 1500;
   localparam int unsigned RANDOM_WORDS   = 60;
   localparam int unsigned BURST_WORDS    = 12;
   localparam int unsigned WATCHDOG_LIMIT = 8_000_000;
   localparam int unsigned TAIL_CYCLES    = 200;
   localparam int unsigned SEND_GAP_MAX   = 40;
   localparam int unsigned RSP_STALL_MAX  = 300;

   typedef logic signed [ppt_pkg::VALUE_BITS-1:0] value_type;

   typedef struct packed {
      logic is_prime;
      logic is_palindrome;
      logic is_prime_palindrome;
   } flag_set_type;

   typedef struct {
      value_type    value;
      flag_set_type flags;
   } pending_result_type;

   typedef enum int {
      KIND_SMALL,
      KIND_NEGATIVE,
      KIND_WIDE,
      KIND_PALINDROME,
      KIND_EDGE
   } value_kind_type;

   logic      clock     = 1'b0;
   logic      reset     = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_ready;
   value_type req_value = '0;
   logic      rsp_valid;
   logic      rsp_ready = 1'b0;
   logic      rsp_is_prime;
   logic      rsp_is_palindrome;
   logic      rsp_is_prime_palindrome;

   pending_result_type expected_results[$];
   int unsigned        error_count    = 0;
   int unsigned        words_sent     = 0;
   int unsigned        words_checked  = 0;
   int unsigned        primes_seen    = 0;
   int unsigned        palins_seen    = 0;
   int unsigned        both_seen      = 0;
   int unsigned        longest_trials = 0;
   int unsigned        idle_cycles    = 0;
   int unsigned        rsp_hold_left  = 0;
   logic               quiet_mode     = 1'b0;

   prime_palindrome_test_core dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_value               (req_value),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_is_prime            (rsp_is_prime),
      .rsp_is_palindrome       (rsp_is_palindrome),
      .rsp_is_prime_palindrome (rsp_is_prime_palindrome)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // classify one word; trials returns how many divisors were tried
   function automatic flag_set_type classify_number(input value_type value,
                                                    output int unsigned trials);
      flag_set_type      flags;
      longint unsigned   num;
      longint unsigned   rest;
      longint unsigned   reversed;
      longint unsigned   divisor;
      flags  = '0;
      trials = 0;
      if (value[ppt_pkg::VALUE_BITS-1]) begin
         return flags;
      end
      num = '0;
      num[ppt_pkg::VALUE_BITS-1:0] = value;
      // trial division up to the square root
      if (num >= 2) begin
         flags.is_prime = 1'b1;
         for (divisor = 2; divisor <= num / divisor; divisor++) begin
            trials++;
            if (num % divisor == 0) begin
               flags.is_prime = 1'b0;
               break;
            end
         end
      end
      // decimal digit reversal
      reversed = 0;
      rest     = num;
      while (rest > 0) begin
         reversed = reversed * 10 + rest % 10;
         rest     = rest / 10;
      end
      flags.is_palindrome       = (reversed == num);
      flags.is_prime_palindrome = flags.is_prime && flags.is_palindrome;
      return flags;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int unsigned pick_gap(input int unsigned long_max);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, long_max);
   endfunction

   // build a palindrome of 1 to 10 digits that fits the positive range
   function automatic value_type random_palindrome();
      int unsigned     num_digits;
      int unsigned     half_digits[10];
      longint unsigned num;
      value_type       value;
      do begin
         num_digits = $urandom_range(1, 10);
         num        = 0;
         for (int i = 0; i < 10; i++) begin
            half_digits[i] = (i == 0 && num_digits > 1) ? $urandom_range(1, 9)
                                                        : $urandom_range(0, 9);
         end
         for (int i = 0; i < num_digits; i++) begin
            num = num * 10 + half_digits[(i < num_digits - 1 - i) ? i
                                                                : num_digits - 1 - i];
         end
      end while (num > (64'd1 << (ppt_pkg::VALUE_BITS - 1)) - 1);
      value = num[ppt_pkg::VALUE_BITS-1:0];
      return value;
   endfunction

   // draw a word of the given kind, redrawing any that would run too long
   function automatic value_type draw_value(input value_kind_type kind);
      value_type    value;
      flag_set_type flags;
      int unsigned  trials;
      do begin
         case (kind)
            KIND_SMALL: begin
               value = $urandom_range(0, 99999);
            end
            KIND_NEGATIVE: begin
               value = $urandom();
               value[ppt_pkg::VALUE_BITS-1] = 1'b1;
            end
            KIND_WIDE: begin
               value = $urandom();
               value[ppt_pkg::VALUE_BITS-1] = 1'b0;
            end
            KIND_PALINDROME: begin
               value = random_palindrome();
            end
            default: begin
               case ($urandom_range(0, 3))
                  0:       value = {1'b0, {(ppt_pkg::VALUE_BITS-1){1'b1}}}
                                 - ppt_pkg::VALUE_BITS'($urandom_range(0, 30));
                  1:       value = {1'b1, {(ppt_pkg::VALUE_BITS-1){1'b0}}}
                                 + ppt_pkg::VALUE_BITS'($urandom_range(0, 30));
                  2:       value = $urandom_range(0, 20);
                  default: value = -ppt_pkg::VALUE_BITS'($urandom_range(1, 20));
               endcase
            end
         endcase
         flags = classify_number(value, trials);
      end while (trials > TRIAL_BUDGET);
      return value;
   endfunction

   task automatic report_mismatch(input string message);
      $display("ERROR: %s", message);
      error_count++;
   endtask

   // send one word and queue its expected flags once accepted
   task automatic send_word(input value_type value);
      int unsigned        gap;
      int unsigned        trials;
      pending_result_type entry;
      gap = quiet_mode ? 0 : pick_gap(SEND_GAP_MAX);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_value   <= value;
      entry.value  = value;
      entry.flags  = classify_number(value, trials);
      do @(posedge clock); while (!req_ready);
      expected_results.push_back(entry);
      words_sent++;
      if (trials > longest_trials) begin
         longest_trials = trials;
      end
   endtask

   // hold the sender until every expected word has come back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   // zero, one, small primes and composites, negatives, both ends of the range and large palindromes
   task automatic test_special_values();
      send_word(0);
      send_word(1);
      send_word(2);
      send_word(3);
      send_word(4);
      send_word(9);
      send_word(10);
      send_word(11);
      send_word(-1);
      send_word(-7);
      send_word({1'b1, {(ppt_pkg::VALUE_BITS-1){1'b0}}});
      send_word(2147483646);
      send_word(2147447412);
      send_word(1000000001);
      send_word(1234554321);
   endtask

   // squares sit right on the trial-divisor limit; the primes 13 and 131 are mixed in
   task automatic test_square_boundaries();
      wait_for_drain();
      send_word(25);
      send_word(49);
      send_word(121);
      send_word(131);
      send_word(13);
      send_word(12321);
      send_word(10201);
      send_word(994009);
      send_word(1003001);
   endtask

   // largest positive value is prime and needs the full divisor sweep
   task automatic test_top_prime();
      send_word({1'b0, {(ppt_pkg::VALUE_BITS-1){1'b1}}});
   endtask

   // no idling on either side
   task automatic test_back_to_back();
      quiet_mode = 1'b1;
      for (int i = 0; i < BURST_WORDS; i++) begin
         send_word(draw_value(i % 2 == 0 ? KIND_SMALL : KIND_NEGATIVE));
      end
      quiet_mode = 1'b0;
   endtask

   // random mix of kinds with random stalls
   task automatic test_random_values();
      int unsigned    roll;
      value_kind_type kind;
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 30) begin
            kind = KIND_SMALL;
         end else if (roll < 50) begin
            kind = KIND_NEGATIVE;
         end else if (roll < 70) begin
            kind = KIND_WIDE;
         end else if (roll < 85) begin
            kind = KIND_PALINDROME;
         end else begin
            kind = KIND_EDGE;
         end
         send_word(draw_value(kind));
      end
   endtask

   // stall the result side at random
   always @(posedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_ready     <= 1'b0;
         rsp_hold_left <= rsp_hold_left - 1;
      end else begin
         rsp_ready     <= 1'b1;
         rsp_hold_left <= quiet_mode ? 0 : pick_gap(RSP_STALL_MAX);
      end
   end

   // compare each accepted result word with the oldest expectation
   always @(posedge clock) begin
      pending_result_type entry;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("result word with no word outstanding");
         end else begin
            entry = expected_results.pop_front();
            words_checked++;
            primes_seen += entry.flags.is_prime;
            palins_seen += entry.flags.is_palindrome;
            both_seen   += entry.flags.is_prime_palindrome;
            if (rsp_is_prime !== entry.flags.is_prime) begin
               report_mismatch($sformatf("value %0d: is_prime %b, want %b",
                  entry.value, rsp_is_prime, entry.flags.is_prime));
            end
            if (rsp_is_palindrome !== entry.flags.is_palindrome) begin
               report_mismatch($sformatf("value %0d: is_palindrome %b, want %b",
                  entry.value, rsp_is_palindrome, entry.flags.is_palindrome));
            end
            if (rsp_is_prime_palindrome !== entry.flags.is_prime_palindrome) begin
               report_mismatch($sformatf("value %0d: is_prime_palindrome %b, want %b",
                  entry.value, rsp_is_prime_palindrome,
                  entry.flags.is_prime_palindrome));
            end
         end
      end
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no word accepted for %0d cycles", idle_cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_special_values();
      test_square_boundaries();
      test_top_prime();
      test_back_to_back();
      test_random_values();
      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d words, %0d checked: %0d prime, %0d palindromic, %0d both",
               words_sent, words_checked, primes_seen, palins_seen, both_seen);
      $display("longest trial division run: %0d divisors, %0d errors",
               longest_trials, error_count);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/ppt_pkg.sv
design/ppt_divider.sv
design/prime_palindrome_test_core.sv
tb/sv/tb_prime_palindrome_test_core.sv
